FILE: src/bfp_pkg.sv
// bit field packer package: payload types, stage record types and fixed constants
// no dependencies; compiled first
package bfp_pkg;

  localparam int WORD_BITS      = 64;
  localparam int WORD_BYTES     = WORD_BITS / 8;
  localparam int MAX_FIELD_BITS = 32;
  localparam int OUT_BITS       = 64;
  localparam int FREE_W         = $clog2(WORD_BITS + 1);
  localparam int FWIDTH_W       = 6;
  localparam int CAP_W          = 18;
  localparam int BYTES_W        = CAP_W + 3;
  localparam int COUNT_W        = 4;

  localparam logic [MAX_FIELD_BITS-1:0] FIELD_MASK = 32'hFFFF_FFFF;
  localparam logic [FREE_W-1:0]         BYTE_ROUND = 7'd7;
  localparam logic [CAP_W-1:0]          CAP_RESET  = 18'd512;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FLUSH = 1'b1
  } bfp_op_t;

  typedef struct packed {
    bfp_op_t             opcode;
    logic [31:0]         field_value;
    logic [FWIDTH_W-1:0] field_width;
  } bfp_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] out_word;
    logic [COUNT_W-1:0]  byte_count;
    logic                overflow;
  } bfp_result_t;

  // one stage's content: valid flag plus payload
  typedef struct packed {
    logic      valid;
    bfp_item_t item;
  } bfp_item_slot_t;

  typedef struct packed {
    logic        valid;
    bfp_result_t result;
  } bfp_result_slot_t;

endpackage

FILE: src/bfp_stream_if.sv
// valid/ready channel interface with a typed payload
// used for the item, result and configuration channels
interface bfp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bfp_in_stage.sv
// input register of the bit field packer
// depends on bfp_pkg and bfp_stream_if
module bfp_in_stage
  import bfp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  bfp_stream_if.sink     items,
  input  logic           advance,
  output bfp_item_slot_t stage
);

  logic      valid;
  bfp_item_t item;

  assign items.ready = !valid || advance;
  assign stage.valid = valid;
  assign stage.item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (items.ready) begin
      valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      item <= items.data;
    end
  end

endmodule

FILE: src/bfp_packer.sv
// packing datapath: accumulator, free bit count and emitted byte count,
// plus the single-pass logic that turns one item into at most one result
// depends on bfp_pkg
module bfp_packer
  import bfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  bfp_item_slot_t   stage,
  input  logic             advance,
  input  logic [CAP_W-1:0] capacity,
  output bfp_result_slot_t res
);

  logic [WORD_BITS-1:0] acc, acc_next;
  logic [FREE_W-1:0]    free, free_next;
  logic [BYTES_W-1:0]   emitted, emitted_next;

  logic [BYTES_W-1:0]        cap_bytes;
  logic [FWIDTH_W-1:0]       w_sat;
  logic [MAX_FIELD_BITS-1:0] data;
  logic [WORD_BITS-1:0]      data_w;
  logic [FREE_W-1:0]         used;
  logic [FREE_W-1:0]         used_round;
  logic [COUNT_W-1:0]        flush_bytes;
  logic                      room_word;
  logic                      room_flush;
  logic [FREE_W-1:0]         free_wrap;
  logic [WORD_BITS-1:0]      word;

  always_comb begin
    cap_bytes   = {capacity, 3'b000};
    w_sat       = (stage.item.field_width > FWIDTH_W'(MAX_FIELD_BITS)) ?
                  FWIDTH_W'(MAX_FIELD_BITS) : stage.item.field_width;
    // a shift by the full field width leaves an empty mask
    data        = stage.item.field_value & (FIELD_MASK >> (FWIDTH_W'(MAX_FIELD_BITS) - w_sat));
    data_w      = WORD_BITS'(data);
    used        = FREE_W'(WORD_BITS) - free;
    used_round  = used + BYTE_ROUND;
    flush_bytes = COUNT_W'(used_round >> 3);
    room_word   = ({1'b0, emitted} + (BYTES_W + 1)'(WORD_BYTES)) <= {1'b0, cap_bytes};
    room_flush  = ({1'b0, emitted} + (BYTES_W + 1)'(flush_bytes)) <= {1'b0, cap_bytes};
    // straddling field: what is left after topping up the current word
    free_wrap   = free + FREE_W'(WORD_BITS) - FREE_W'(w_sat);
    word        = acc | (data_w >> (FREE_W'(w_sat) - free));

    acc_next     = acc;
    free_next    = free;
    emitted_next = emitted;
    res          = '0;

    if (stage.item.opcode == OP_FLUSH) begin
      if (free != FREE_W'(WORD_BITS)) begin
        res.valid = 1'b1;
        if (!room_flush) begin
          res.result.overflow = 1'b1;
        end else begin
          res.result.out_word   = OUT_BITS'(acc) << (OUT_BITS - WORD_BITS);
          res.result.byte_count = flush_bytes;
          emitted_next          = emitted + BYTES_W'(flush_bytes);
          acc_next              = '0;
          free_next             = FREE_W'(WORD_BITS);
        end
      end
    end else begin
      if (!room_word) begin
        res.valid           = 1'b1;
        res.result.overflow = 1'b1;
      end else if (w_sat != '0) begin
        if (FREE_W'(w_sat) <= free) begin
          acc_next  = acc | (data_w << (free - FREE_W'(w_sat)));
          free_next = free - FREE_W'(w_sat);
        end else begin
          res.valid             = 1'b1;
          res.result.out_word   = OUT_BITS'(word) << (OUT_BITS - WORD_BITS);
          res.result.byte_count = COUNT_W'(WORD_BYTES);
          emitted_next          = emitted + BYTES_W'(WORD_BYTES);
          free_next             = free_wrap;
          acc_next              = data_w << free_wrap;
        end
      end
    end

    if (!stage.valid) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      free    <= FREE_W'(WORD_BITS);
      emitted <= '0;
    end else if (advance) begin
      acc     <= acc_next;
      free    <= free_next;
      emitted <= emitted_next;
    end
  end

endmodule

FILE: src/bfp_out_stage.sv
// result register of the bit field packer
// depends on bfp_pkg and bfp_stream_if
module bfp_out_stage
  import bfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  bfp_result_slot_t res,
  input  logic             load,
  output logic             slot_free,
  bfp_stream_if.source     results
);

  logic        valid;
  bfp_result_t result;

  assign slot_free     = !valid || results.ready;
  assign results.valid = valid;
  assign results.data  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res.result;
    end
  end

endmodule

FILE: src/bit_field_packer_unit.sv
// top level of the bit field packer: capacity register and the stage chain
// depends on bfp_pkg, bfp_stream_if, bfp_in_stage, bfp_packer, bfp_out_stage
//
// Packs fields of 1 to 32 bits, most significant bit first, into a 64-bit
// accumulator and hands out full words (byte_count 8) or flushed partial
// words, left-aligned, with overflow set when the configured capacity would
// be exceeded. The block takes one item per clock unless a stalled result holds
// the input register; an item is registered in the input register and, as it
// retires, its result is loaded into the result register, which hands it out. A
// stalled result register holds an item that has a result in the input
// register, after which items wait. capacity (in words) resets to 512 and is
// written through cfg, which is always ready; write it only while idle.
module bit_field_packer_unit
  import bfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  bfp_stream_if.sink   items,
  bfp_stream_if.source results,
  bfp_stream_if.sink   cfg
);

  logic [CAP_W-1:0] capacity;
  bfp_item_slot_t   stage;
  bfp_result_slot_t res;
  logic             slot_free;
  logic             advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  // the item retires when it has no result or the result register can take it
  assign advance = stage.valid && (!res.valid || slot_free);

  bfp_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .advance (advance),
    .stage   (stage)
  );

  bfp_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .advance  (advance),
    .capacity (capacity),
    .res      (res)
  );

  bfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .load      (advance && res.valid),
    .slot_free (slot_free),
    .results   (results)
  );

endmodule

FILE: tb/bit_field_packer_unit_tb.sv
// testbench for bit_field_packer_unit: packs random and directed fields, checks every word
// depends on bfp_pkg, bfp_stream_if and the rtl under src
`timescale 1ns / 1ps

module bit_field_packer_unit_tb;
  import bfp_pkg::*;

  localparam int HOLD_CYCLES = 60;

  class packer_scoreboard;
    logic [63:0]          acc_bits;
    int unsigned          free_cnt;
    int unsigned          bytes_out;
    int unsigned          cap_words;
    bfp_result_t          expected_words[$];
    int                   errors;

    function void clear_state();
      acc_bits = '0;
      free_cnt = WORD_BITS;
      bytes_out = 0;
      cap_words = 32'(CAP_RESET);
      expected_words.delete();
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] words);
      cap_words = 32'(words);
    endfunction

    function void push_word(logic [63:0] word, int unsigned count, logic ovf);
      bfp_result_t r;
      r.out_word = word;
      r.byte_count = count[COUNT_W-1:0];
      r.overflow = ovf;
      expected_words.push_back(r);
    endfunction

    // called on each accepted input transfer
    function void predict_item(bfp_item_t it);
      int unsigned cap_bytes;
      int unsigned nbytes;
      int unsigned w;
      logic [63:0] data;
      logic [63:0] word;
      cap_bytes = cap_words * 8;
      if (it.opcode == OP_FLUSH) begin
        if (free_cnt >= WORD_BITS) return;
        nbytes = (WORD_BITS - free_cnt + 7) >> 3;
        if (bytes_out + nbytes > cap_bytes) begin
          push_word('0, 0, 1'b1);
          return;
        end
        push_word(acc_bits, nbytes, 1'b0);
        bytes_out += nbytes;
        acc_bits = '0;
        free_cnt = WORD_BITS;
        return;
      end
      // capacity is checked before the width is even looked at
      if (bytes_out + WORD_BYTES > cap_bytes) begin
        push_word('0, 0, 1'b1);
        return;
      end
      w = 32'(it.field_width);
      if (w > MAX_FIELD_BITS) w = MAX_FIELD_BITS;
      if (w == 0) return;
      data = {32'd0, it.field_value & (FIELD_MASK >> (32 - w))};
      if (w <= free_cnt) begin
        acc_bits = acc_bits | (data << (free_cnt - w));
        free_cnt = free_cnt - w;
        return;
      end
      // field straddles the word boundary
      word = acc_bits | (data >> (w - free_cnt));
      push_word(word, WORD_BYTES, 1'b0);
      bytes_out += WORD_BYTES;
      free_cnt = WORD_BITS - w + free_cnt;
      acc_bits = data << free_cnt;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(bfp_result_t got);
      bfp_result_t exp;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result word=%h count=%0d ovf=%0d",
                                  got.out_word, got.byte_count, got.overflow));
        return;
      end
      exp = expected_words.pop_front();
      if (got.out_word !== exp.out_word)
        report_mismatch($sformatf("out_word %h, expected %h", got.out_word, exp.out_word));
      if (got.byte_count !== exp.byte_count)
        report_mismatch($sformatf("byte_count %0d, expected %0d",
                                  got.byte_count, exp.byte_count));
      if (got.overflow !== exp.overflow)
        report_mismatch($sformatf("overflow %0d, expected %0d", got.overflow, exp.overflow));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  bit   hold_req;

  bfp_stream_if #(.payload_t(bfp_item_t))        items_if ();
  bfp_stream_if #(.payload_t(bfp_result_t))      results_if ();
  bfp_stream_if #(.payload_t(logic [CAP_W-1:0])) cfg_if ();

  packer_scoreboard sb;

  bit_field_packer_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        results_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        results_if.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      sb.check_word(results_if.data);
  end

  function automatic bfp_item_t make_item(bfp_op_t op, logic [31:0] v, logic [5:0] w);
    bfp_item_t it;
    it.opcode = op;
    it.field_value = v;
    it.field_width = w;
    return it;
  endfunction

  function automatic bfp_item_t random_item();
    int unsigned pick;
    logic [31:0] v;
    logic [5:0]  w;
    pick = $urandom_range(0, 99);
    v = $urandom;
    if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 1) ? FIELD_MASK : 32'd0;
    if (pick < 6) return make_item(OP_FLUSH, v, 6'($urandom_range(0, 63)));
    if (pick < 11)      w = 6'd0;
    else if (pick < 18) w = 6'($urandom_range(33, 63));
    else if (pick < 26) w = 6'd32;
    else                w = 6'($urandom_range(1, 31));
    return make_item(OP_WRITE, v, w);
  endfunction

  task automatic send_item(bfp_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.data <= it;
    do @(posedge clk); while (!items_if.ready);
    sb.predict_item(it);
  endtask

  // only while idle: the last item may still be in flight with no result
  task automatic write_capacity(logic [CAP_W-1:0] words);
    items_if.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= words;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_capacity(words);
  endtask

  task automatic run_random(int n, int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      send_item(random_item());
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    quiet = 1'b0;
    hold_req = 1'b0;
    rst <= 1'b1;
    items_if.valid <= 1'b0;
    items_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // exact fill, then flush of a full word, then flush of nothing
    send_item(make_item(OP_WRITE, 32'hFFFF_FFFF, 6'd32));
    send_item(make_item(OP_WRITE, 32'h0000_0000, 6'd32));
    send_item(make_item(OP_FLUSH, 32'h0, 6'd0));
    send_item(make_item(OP_FLUSH, 32'hFFFF_FFFF, 6'd63));
    send_item(make_item(OP_WRITE, 32'h0000_0005, 6'd0));
    // oversized width saturates, exact fill stays until the next write
    send_item(make_item(OP_WRITE, 32'h0000_0001, 6'd1));
    send_item(make_item(OP_WRITE, 32'hA5A5_A5A5, 6'd63));
    send_item(make_item(OP_WRITE, 32'hFFFF_FFFF, 6'd31));
    send_item(make_item(OP_WRITE, 32'hFFFF_FFFE, 6'd1));
    send_item(make_item(OP_WRITE, 32'h1234_5678, 6'd32));
    send_item(make_item(OP_WRITE, 32'h8000_0001, 6'd32));
    send_item(make_item(OP_FLUSH, 32'h0, 6'd0));
    send_item(make_item(OP_WRITE, 32'hFFFF_FF7F, 6'd7));
    send_item(make_item(OP_FLUSH, 32'h0, 6'd0));
    send_item(make_item(OP_WRITE, 32'h0000_01AB, 6'd9));
    send_item(make_item(OP_FLUSH, 32'h0, 6'd0));
    send_item(make_item(OP_WRITE, 32'hFFFF_FFFF, 6'd33));
    send_item(make_item(OP_WRITE, 32'h7FFF_FFFF, 6'd31));
    send_item(make_item(OP_WRITE, 32'h0001_FFFF, 6'd17));

    // zero capacity: writes of any width and the non-empty flush all overflow
    write_capacity('0);
    send_item(make_item(OP_WRITE, 32'h0000_00FF, 6'd8));
    send_item(make_item(OP_WRITE, 32'h0, 6'd0));
    send_item(make_item(OP_FLUSH, 32'h0, 6'd0));

    write_capacity(18'd131072);
    run_random(300, 120);

    write_capacity(18'd1);
    run_random(30, -1);

    // capacity just above what has gone out, so overflow starts mid-phase
    for (int k = 0; k < 3; k++) begin
      write_capacity(CAP_W'((sb.bytes_out + 7) / 8 + 3));
      run_random(60, -1);
    end

    write_capacity(CAP_RESET + 18'd1024);
    run_random(80, -1);
    quiet = 1'b1;
    run_random(120, -1);

    items_if.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
src/bfp_pkg.sv
src/bfp_stream_if.sv
src/bfp_in_stage.sv
src/bfp_packer.sv
src/bfp_out_stage.sv
src/bit_field_packer_unit.sv
tb/bit_field_packer_unit_tb.sv
